### hdl/fue_pkg.sv
package fue_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int IDX_W = 3;

	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam logic [7:0] PLUS_CHAR = 8'h2B;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] LF_CHAR = 8'h0A;

	localparam logic [IDX_W-1:0] LIT_LAST = 3'd0;
	localparam logic [IDX_W-1:0] HEX_LAST = 3'd2;
	localparam logic [IDX_W-1:0] NL_LAST = 3'd5;

	localparam logic [7:0] HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	// %0D%0A
	localparam logic [7:0] NL_SEQ [6] = '{
		8'h25, 8'h30, 8'h44, 8'h25, 8'h30, 8'h41
	};

	typedef enum logic [1:0] {
		KIND_LIT = 2'd0,
		KIND_HEX = 2'd1,
		KIND_NL  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] lit;
		logic [7:0] hi_char;
		logic [7:0] lo_char;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

	function automatic logic is_verbatim(input logic [7:0] b);
		logic ok;
		ok = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A) || b == 8'h2D || b == 8'h5F ||
			b == 8'h2E || b == 8'h2A;
		return ok;
	endfunction

endpackage

### hdl/fue_in_if.sv
interface fue_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_end;

	modport source(output valid, in_byte, in_end, input ready);
	modport sink(input valid, in_byte, in_end, output ready);
endinterface

### hdl/fue_out_if.sv
interface fue_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;

	modport source(output valid, out_byte, run_last, string_end, input ready);
	modport sink(input valid, out_byte, run_last, string_end, output ready);
endinterface

### hdl/fue_front.sv
module fue_front import fue_pkg::*; (
	fue_in_if.sink  in_ch,
	input  qstat_t  stat,
	output logic    push,
	output entry_t  entry
);

	assign in_ch.ready = !stat.full;
	assign push        = in_ch.valid && !stat.full;

	always_comb begin
		entry.lit     = in_ch.in_byte;
		entry.hi_char = HEX_DIGITS[in_ch.in_byte[7:4]];
		entry.lo_char = HEX_DIGITS[in_ch.in_byte[3:0]];
		entry.last    = in_ch.in_end;
		if (is_verbatim(in_ch.in_byte)) begin
			entry.kind = KIND_LIT;
		end else if (in_ch.in_byte == SPACE_CHAR) begin
			entry.kind = KIND_LIT;
			entry.lit  = PLUS_CHAR;
		end else if (in_ch.in_byte == LF_CHAR) begin
			entry.kind = KIND_NL;
		end else begin
			entry.kind = KIND_HEX;
		end
	end

endmodule

### hdl/fue_queue.sv
module fue_queue import fue_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output qstat_t stat
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

### hdl/fue_back.sv
module fue_back import fue_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  entry_t  head,
	input  qstat_t  stat,
	output logic    pop,
	fue_out_if.source out_ch
);

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             run_last_q;
	logic             string_end_q;

	logic [IDX_W-1:0] last_idx;
	logic [7:0]       step_byte;
	logic             step_last;
	logic             load;
	logic             take;

	always_comb begin
		unique case (head.kind)
			KIND_LIT: begin
				last_idx  = LIT_LAST;
				step_byte = head.lit;
			end
			KIND_HEX: begin
				last_idx = HEX_LAST;
				case (idx_q)
					3'd0:    step_byte = PCT_CHAR;
					3'd1:    step_byte = head.hi_char;
					default: step_byte = head.lo_char;
				endcase
			end
			KIND_NL: begin
				last_idx  = NL_LAST;
				step_byte = (idx_q <= NL_LAST) ? NL_SEQ[idx_q] : PCT_CHAR;
			end
			default: begin
				last_idx  = LIT_LAST;
				step_byte = head.lit;
			end
		endcase
	end

	assign step_last = (idx_q == last_idx);
	assign load      = !out_valid_q || out_ch.ready;
	assign take      = load && !stat.empty;
	assign pop       = take && step_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= !stat.empty;
			if (take) begin
				idx_q <= step_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q   <= step_byte;
			run_last_q   <= step_last;
			string_end_q <= step_last && head.last;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_byte   = out_byte_q;
	assign out_ch.run_last   = run_last_q;
	assign out_ch.string_end = string_end_q;

endmodule

### hdl/form_url_percent_encoder_unit.sv
// Channel  Dir  Payload                          Handshake
// in_ch    in   in_byte[7:0], in_end             valid/ready
// out_ch   out  out_byte[7:0], run_last, string_end  valid/ready
//
// One output byte per cycle unless out_ch stalls or the queue is empty;
// letters, digits, - _ . * and space give one byte, other bytes three
// and newline six, paced by the back end's step counter.
// Reset clears the queue pointers, step counter and output valid.
// A two-entry queue lets the input keep flowing while output is stalled.
module form_url_percent_encoder_unit import fue_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	fue_in_if.sink    in_ch,
	fue_out_if.source out_ch
);

	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t head;
	qstat_t stat;

	fue_front u_front (
		.in_ch (in_ch),
		.stat  (stat),
		.push  (push),
		.entry (push_entry)
	);

	fue_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (stat)
	);

	fue_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

`ifndef NO_ASSERTIONS
	a_qcount: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= QCNT_W'(QDEPTH))
		else $error("queue overfilled");

	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !stat.empty)
		else $error("accepted item not queued");

	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.string_end) |-> out_ch.run_last)
		else $error("string end off a run boundary");
`endif

endmodule
